@@ src/i2cmbe_pkg.sv @@
// Shared types, operation codes and helper functions for the I2C master bit engine.
// No dependencies; every other file in src imports this package.
package i2cmbe_pkg;

  localparam int unsigned PHASE_W = 16;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SUB_W   = 2;

  localparam logic [PHASE_W-1:0] PHASE_RESET = 16'd55;

  // Command codes, same encoding as req_type on the input channel
  localparam logic [OP_W-1:0] OP_IDLE      = 3'd0;
  localparam logic [OP_W-1:0] OP_START     = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE     = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_ACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_NACK = 3'd5;

  // Phase counts per command
  localparam logic [STEP_W-1:0] STEPS_COND  = 5'd3;
  localparam logic [STEP_W-1:0] STEPS_WRITE = 5'd27;
  localparam logic [STEP_W-1:0] STEPS_READ  = 5'd28;

  // Landmark phases inside a byte transfer
  localparam logic [STEP_W-1:0] STEP_BITS_END = 5'd24;
  localparam logic [STEP_W-1:0] STEP_ACK_REL  = 5'd24;
  localparam logic [STEP_W-1:0] STEP_ACK_HIGH = 5'd25;
  localparam logic [STEP_W-1:0] STEP_RACK_SDA = 5'd25;
  localparam logic [STEP_W-1:0] STEP_RACK_HI  = 5'd26;

  // Position inside a three-phase bit slot
  localparam logic [SUB_W-1:0] SUB_0    = 2'd0;
  localparam logic [SUB_W-1:0] SUB_1    = 2'd1;
  localparam logic [SUB_W-1:0] SUB_LAST = 2'd2;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] wr_data;
    logic              sda_in;
  } cmd_t;

  typedef struct packed {
    logic scl_out;
    logic sda_out;
    logic busy_res;
    logic done_res;
    logic [BYTE_W-1:0] rd_data;
    logic ack_ok;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Map a raw request code to a command; unknown codes become idle
  function automatic logic [OP_W-1:0] classify(input logic [OP_W-1:0] req);
    logic [OP_W-1:0] op;
    op = OP_IDLE;
    if (req >= OP_START && req <= OP_READ_NACK) begin
      op = req;
    end
    return op;
  endfunction

  function automatic logic [STEP_W-1:0] step_total(input logic [OP_W-1:0] op);
    logic [STEP_W-1:0] n;
    if (op == OP_START || op == OP_STOP) begin
      n = STEPS_COND;
    end else if (op == OP_WRITE) begin
      n = STEPS_WRITE;
    end else begin
      n = STEPS_READ;
    end
    return n;
  endfunction

endpackage

@@ src/i2cmbe_if.sv @@
// Valid/ready channel interfaces for the I2C master bit engine.
// Depends on i2cmbe_pkg for field widths.
interface i2cmbe_in_if;
  import i2cmbe_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   req_type;
  logic [BYTE_W-1:0] wr_data;
  logic              sda_in;
  modport source (output valid, output req_type, output wr_data, output sda_in, input ready);
  modport sink   (input valid, input req_type, input wr_data, input sda_in, output ready);
endinterface

interface i2cmbe_out_if;
  import i2cmbe_pkg::*;
  logic              valid;
  logic              ready;
  logic              scl_out;
  logic              sda_out;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] rd_data;
  logic              ack_ok;
  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output rd_data, output ack_ok, input ready);
  modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input rd_data, input ack_ok, output ready);
endinterface

interface i2cmbe_cfg_if;
  import i2cmbe_pkg::*;
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/i2cmbe_front.sv @@
// Front end: accepts ticks from the input channel and classifies the request code.
// Depends on i2cmbe_pkg and i2cmbe_in_if.
module i2cmbe_front (
  i2cmbe_in_if.sink         in_ch,
  input  i2cmbe_pkg::q_stat_t q_stat,
  output logic              q_push,
  output i2cmbe_pkg::cmd_t  q_wdata
);
  import i2cmbe_pkg::*;

  assign in_ch.ready     = !q_stat.full;
  assign q_push          = in_ch.valid && !q_stat.full;
  assign q_wdata.op      = classify(in_ch.req_type);
  assign q_wdata.wr_data = in_ch.wr_data;
  assign q_wdata.sda_in  = in_ch.sda_in;

endmodule

@@ src/i2cmbe_queue.sv @@
// Short FIFO of classified ticks between the front end and the line sequencer.
// Depends on i2cmbe_pkg.
module i2cmbe_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  i2cmbe_pkg::cmd_t    wdata,
  input  logic                pop,
  output i2cmbe_pkg::cmd_t    rdata,
  output i2cmbe_pkg::q_stat_t stat
);
  import i2cmbe_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

@@ src/i2cmbe_back.sv @@
// Back end: phase timer, bus line sequencer, phase-length register and result register.
// Depends on i2cmbe_pkg, i2cmbe_out_if and i2cmbe_cfg_if.
module i2cmbe_back (
  input  logic                clk,
  input  logic                rst_n,
  i2cmbe_cfg_if.sink          cfg_ch,
  i2cmbe_out_if.source        out_ch,
  input  i2cmbe_pkg::cmd_t    q_rdata,
  input  i2cmbe_pkg::q_stat_t q_stat,
  output logic                q_pop
);
  import i2cmbe_pkg::*;

  logic [PHASE_W-1:0] pc_r;
  logic [PHASE_W-1:0] cnt_r, cnt_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SUB_W-1:0]   sub_r, sub_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               ack_r, ack_nxt;
  logic [BYTE_W-1:0]  rdb_r, rdb_nxt;
  logic               oval_r;
  res_t               res_r, res_nxt;

  logic [PHASE_W-1:0] limit;
  logic [PHASE_W-1:0] cnt_inc;
  logic [STEP_W-1:0]  step_inc;
  logic [SUB_W-1:0]   sub_inc;
  logic               done;
  logic               enter;
  logic               is_read;

  assign cfg_ch.ready = 1'b1;
  assign q_pop        = !q_stat.empty && (!oval_r || out_ch.ready);

  assign limit    = (pc_r == '0) ? PHASE_W'(1) : pc_r;
  assign cnt_inc  = cnt_r + 1'b1;
  assign step_inc = step_r + 1'b1;
  assign sub_inc  = (sub_r == SUB_LAST) ? SUB_0 : sub_r + 1'b1;
  assign is_read  = (op_r == OP_READ_ACK) || (op_r == OP_READ_NACK);

  always_comb begin
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    sub_nxt   = sub_r;
    op_nxt    = op_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rdb_nxt   = rdb_r;
    done      = 1'b0;
    enter     = 1'b0;

    if (op_r != OP_IDLE) begin
      if (cnt_inc >= limit) begin
        cnt_nxt = '0;
        // sample on the last tick of the SCL-high phase
        if (op_r == OP_WRITE && step_r == STEP_ACK_HIGH) begin
          ack_nxt = !q_rdata.sda_in;
        end else if (is_read && step_r >= 5'd1 && step_r <= STEP_BITS_END &&
                     sub_r == SUB_0) begin
          rdb_nxt = {rdb_r[BYTE_W-2:0], q_rdata.sda_in};
        end
        if (step_inc >= step_total(op_r)) begin
          op_nxt   = OP_IDLE;
          step_nxt = '0;
          done     = 1'b1;
        end else begin
          step_nxt = step_inc;
          sub_nxt  = sub_inc;
          enter    = 1'b1;
        end
      end else begin
        cnt_nxt = cnt_inc;
      end
    end else if (q_rdata.op != OP_IDLE) begin
      op_nxt   = q_rdata.op;
      step_nxt = '0;
      cnt_nxt  = '0;
      // read slots start one phase late, so phase 1 is slot position 0
      sub_nxt  = (q_rdata.op == OP_READ_ACK || q_rdata.op == OP_READ_NACK) ? SUB_LAST : SUB_0;
      if (q_rdata.op == OP_WRITE) begin
        shift_nxt = q_rdata.wr_data;
      end
      enter = 1'b1;
    end

    // apply line levels on the first tick of the new phase
    if (enter) begin
      unique case (op_nxt) inside
        OP_START: begin
          if (step_nxt == 5'd0) begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b1;
          end else if (step_nxt == 5'd1) begin
            sda_nxt = 1'b0;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        OP_STOP: begin
          if (step_nxt == 5'd0) begin
            scl_nxt = 1'b0;
            sda_nxt = 1'b0;
          end else if (step_nxt == 5'd1) begin
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = 1'b1;
          end
        end
        OP_WRITE: begin
          if (step_nxt < STEP_BITS_END) begin
            if (sub_nxt == SUB_0) begin
              sda_nxt   = shift_nxt[BYTE_W-1];
              shift_nxt = {shift_nxt[BYTE_W-2:0], 1'b0};
            end else if (sub_nxt == SUB_1) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
            end
          end else if (step_nxt == STEP_ACK_REL) begin
            sda_nxt = 1'b1;
          end else if (step_nxt == STEP_ACK_HIGH) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        OP_READ_ACK, OP_READ_NACK: begin
          if (step_nxt == 5'd0) begin
            sda_nxt = 1'b1;
          end else if (step_nxt <= STEP_BITS_END) begin
            if (sub_nxt == SUB_0) begin
              scl_nxt = 1'b1;
            end else if (sub_nxt == SUB_LAST) begin
              scl_nxt = 1'b0;
            end
          end else if (step_nxt == STEP_RACK_SDA) begin
            sda_nxt = (op_nxt == OP_READ_ACK) ? 1'b0 : 1'b1;
          end else if (step_nxt == STEP_RACK_HI) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    res_nxt.scl_out  = scl_nxt;
    res_nxt.sda_out  = sda_nxt;
    res_nxt.busy_res = (op_nxt != OP_IDLE);
    res_nxt.done_res = done;
    res_nxt.rd_data  = rdb_nxt;
    res_nxt.ack_ok   = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= PHASE_RESET;
      cnt_r   <= '0;
      step_r  <= '0;
      sub_r   <= SUB_0;
      op_r    <= OP_IDLE;
      shift_r <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      rdb_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        pc_r <= cfg_ch.data;
      end
      if (q_pop) begin
        cnt_r   <= cnt_nxt;
        step_r  <= step_nxt;
        sub_r   <= sub_nxt;
        op_r    <= op_nxt;
        shift_r <= shift_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ack_r   <= ack_nxt;
        rdb_r   <= rdb_nxt;
        oval_r  <= 1'b1;
      end else if (out_ch.ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid    = oval_r;
  assign out_ch.scl_out  = res_r.scl_out;
  assign out_ch.sda_out  = res_r.sda_out;
  assign out_ch.busy_res = res_r.busy_res;
  assign out_ch.done_res = res_r.done_res;
  assign out_ch.rd_data  = res_r.rd_data;
  assign out_ch.ack_ok   = res_r.ack_ok;

endmodule

@@ src/i2c_master_bit_engine.sv @@
// I2C master bit engine: one tick word in, one line-state word out.
// Result path: an accepted tick is written into a queue slot, then into the result register.
// Throughput: 1 word per cycle while out_ch.ready is high; a held result stalls the sequencer.
// Reset (rst_n low, synchronous): idle, SCL and SDA released high, phase length 55, queue empty.
// Depends on i2cmbe_pkg, the channel interfaces, and the front, queue and back modules.
module i2c_master_bit_engine (
  input  logic         clk,
  input  logic         rst_n,
  i2cmbe_in_if.sink    in_ch,
  i2cmbe_out_if.source out_ch,
  i2cmbe_cfg_if.sink   cfg_ch
);
  import i2cmbe_pkg::*;

  logic    q_push;
  logic    q_pop;
  cmd_t    q_wdata;
  cmd_t    q_rdata;
  q_stat_t q_stat;

  i2cmbe_front u_front (
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  i2cmbe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  i2cmbe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch),
    .q_rdata (q_rdata),
    .q_stat  (q_stat),
    .q_pop   (q_pop)
  );

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.done_res) |-> !out_ch.busy_res)
    else $error("done and busy both set in one result");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("sequencer popped an empty queue");

  a_pop_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_ch.valid)
    else $error("popped tick produced no result");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into a full queue");

endmodule
